@@ hdl/u8sd_pkg.sv @@
package u8sd_pkg;

	localparam int unsigned QueueDepth = 4;

	localparam logic [31:0] OFS1 = 32'h0000_3080;
	localparam logic [31:0] OFS2 = 32'h000E_2080;
	localparam logic [31:0] OFS3 = 32'h03C8_2080;
	localparam logic [31:0] OFS4 = 32'hFA08_2080;
	localparam logic [31:0] OFS5 = 32'h8208_2080;

	// classified byte as it travels from front to back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
		logic [2:0] trail;
	} item_t;

	// trailing byte count implied by a lead byte
	function automatic logic [2:0] trail_of(input logic [7:0] b);
		logic [2:0] t;
		case (b) inside
			[8'hC0:8'hDF]: t = 3'd1;
			[8'hE0:8'hEF]: t = 3'd2;
			[8'hF0:8'hF7]: t = 3'd3;
			[8'hF8:8'hFB]: t = 3'd4;
			[8'hFC:8'hFF]: t = 3'd5;
			default:       t = 3'd0;
		endcase
		return t;
	endfunction

	// offset removed from the folded value for each trailing count
	function automatic logic [31:0] len_offset(input logic [2:0] tc);
		logic [31:0] o;
		case (tc)
			3'd1:    o = OFS1;
			3'd2:    o = OFS2;
			3'd3:    o = OFS3;
			3'd4:    o = OFS4;
			3'd5:    o = OFS5;
			default: o = 32'd0;
		endcase
		return o;
	endfunction

endpackage

@@ hdl/utf8_stream_decoder.sv @@
// utf8 stream decoder: one byte per item, zero or one result per item
// path: an accepted byte is registered in the front, written to the queue, and its result registered on the output
// throughput: one byte per cycle while the output is not stalled, set by the accumulator update in the back end
// a 4-entry queue between classifier and accumulator absorbs output stalls
// reset: arst_n asynchronous active low; clears queue, accumulator, open sequence, valids
module utf8_stream_decoder import u8sd_pkg::*; #(
	parameter int unsigned DEPTH = QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_string,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] code_point,
	output logic [2:0]  sequence_length,
	output logic        incomplete
);

	// front to queue
	item_t item_s1;
	logic  push;
	logic  q_full;

	// queue to back
	item_t rd_item;
	logic  pop;
	logic  q_empty;

	// front: registers the byte and works out the trailing count it would imply
	// as a lead byte; whether it is one is decided in the back end
	u8sd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.end_of_string (end_of_string),
		.q_full        (q_full),
		.push          (push),
		.item_s1       (item_s1)
	);

	// short queue so the input keeps flowing while a result waits
	u8sd_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (item_s1),
		.full    (q_full),
		.pop     (pop),
		.empty   (q_empty),
		.rd_item (rd_item)
	);

	// back: shift-by-6 accumulator, offset removal at end of sequence,
	// incomplete result when the string ends inside a sequence
	u8sd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.rd_item         (rd_item),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.code_point      (code_point),
		.sequence_length (sequence_length),
		.incomplete      (incomplete)
	);

endmodule

@@ hdl/u8sd_front.sv @@
module u8sd_front import u8sd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_string,
	input  logic       q_full,
	output logic       push,
	output item_t      item_s1
);

	logic vld_s1;

	assign in_stall = vld_s1 && q_full;
	assign push     = vld_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.data_byte     <= data_byte;
			item_s1.end_of_string <= end_of_string;
			item_s1.trail         <= trail_of(data_byte);
		end
	end

endmodule

@@ hdl/u8sd_queue.sv @@
module u8sd_queue import u8sd_pkg::*; #(
	parameter int unsigned DEPTH = QueueDepth
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wr_item,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output item_t rd_item
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);

	item_t         slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

@@ hdl/u8sd_back.sv @@
module u8sd_back import u8sd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  item_t       rd_item,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] code_point,
	output logic [2:0]  sequence_length,
	output logic        incomplete
);

	logic [31:0] acc_q;
	logic [2:0]  rem_q;
	logic [2:0]  tc_q;

	logic [31:0] acc_n;
	logic [2:0]  rem_n;
	logic [2:0]  tc_n;
	logic        done;
	logic        cut;
	logic        take;

	assign take = !out_valid || !out_stall;
	assign pop  = !q_empty && take;

	always_comb begin
		if (rem_q == 3'd0) begin
			tc_n  = rd_item.trail;
			rem_n = rd_item.trail;
			acc_n = {24'd0, rd_item.data_byte};
		end else begin
			tc_n  = tc_q;
			rem_n = rem_q - 3'd1;
			acc_n = (acc_q << 6) + {24'd0, rd_item.data_byte};
		end
		done = (rem_n == 3'd0);
		cut  = !done && rd_item.end_of_string;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			rem_q     <= '0;
			tc_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (take) begin
				out_valid <= pop && (done || cut);
			end
			if (pop) begin
				if (done || cut) begin
					acc_q <= '0;
					rem_q <= '0;
					tc_q  <= '0;
				end else begin
					acc_q <= acc_n;
					rem_q <= rem_n;
					tc_q  <= tc_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && done) begin
			code_point      <= acc_n - len_offset(tc_n);
			sequence_length <= tc_n + 3'd1;
			incomplete      <= 1'b0;
		end else if (pop && cut) begin
			code_point      <= '0;
			sequence_length <= tc_n + 3'd1 - rem_n;
			incomplete      <= 1'b1;
		end
	end

endmodule

@@ hdl/u8sd_checker.sv @@
module u8sd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] code_point,
	input logic [2:0]  sequence_length,
	input logic        incomplete
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(code_point)
			&& $stable(sequence_length) && $stable(incomplete))
		else $error("stalled result changed");

	// an incomplete result carries no code point
	a_inc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && incomplete |-> code_point == 32'd0)
		else $error("incomplete result with nonzero code point");

	// a complete sequence is one to six bytes long
	a_len_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !incomplete |-> sequence_length != 3'd0 && sequence_length != 3'd7)
		else $error("bad length on complete result");

	// a dropped sequence had at least one and at most five bytes
	a_len_part: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && incomplete |-> sequence_length != 3'd0 && sequence_length != 3'd6
			&& sequence_length != 3'd7)
		else $error("bad length on incomplete result");

endmodule

bind utf8_stream_decoder u8sd_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.code_point      (code_point),
	.sequence_length (sequence_length),
	.incomplete      (incomplete)
);
